>>> design/mobt_pkg.sv
// Package for the multicart outer-bank translator.
// Holds request kinds, layout variant codes, register indexes and shared types.
// No dependencies.
package mobt_pkg;

   localparam int unsigned NumOuterRegs = 8;
   localparam int unsigned BankWidth    = 13;
   localparam int unsigned ChipWidth    = 13;

   // Request kinds carried in the request tuser field (code 3 is dropped)
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_PRG   = 2'd1,
      KIND_CHR   = 2'd2
   } req_kind_type;

   // Layout family: board_variant with its low bit dropped
   typedef enum logic [2:0] {
      FAM_BASE0   = 3'd0,
      FAM_REV_R1  = 3'd1,
      FAM_PRG_HI  = 3'd2,
      FAM_TWO_CHP = 3'd3,
      FAM_CHR_WP  = 3'd4,
      FAM_SINGLE  = 3'd5,
      FAM_BASE6   = 3'd6,
      FAM_BASE7   = 3'd7
   } layout_fam_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_BOARD_VARIANT   = 2'd0;
   localparam logic [1:0] CSR_CHIP_HALF_BANKS = 2'd1;
   localparam logic [1:0] CSR_CHR_RAM_PRESENT = 2'd2;

   // Outer register indexes and bits
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_OUTER1  = 3'd1;
   localparam logic [2:0] REG_CHR_HI  = 3'd2;
   localparam logic [2:0] REG_LOCK    = 3'd3;
   localparam logic [2:0] REG_RAM_WIN = 3'd4;
   localparam int unsigned LOCK_BIT   = 7;

   localparam logic [7:0]  REG2_KEEP_MASK = 8'hF1;
   localparam logic [7:0]  CHR_MASK_HALF  = 8'h7F;
   localparam logic [7:0]  CHR_MASK_FULL  = 8'hFF;
   localparam logic [12:0] CHIP_DEFAULT   = 13'h0100;

   typedef logic [NumOuterRegs-1:0][7:0] outer_regs_type;

   // Staged register write from the input stage
   typedef struct packed {
      logic       valid;
      logic [2:0] idx;
      logic [7:0] data;
   } wr_cmd_type;

   // Board configuration
   typedef struct packed {
      logic [3:0]           board_variant;
      logic [ChipWidth-1:0] chip_half_banks;
      logic                 chr_ram_present;
   } board_cfg_type;

   // One translated result
   typedef struct packed {
      logic [1:0]           mirror_mode;
      logic                 chr_write_enable;
      logic                 use_chr_ram;
      logic [BankWidth-1:0] bank_number;
   } result_type;

endpackage

>>> design/mobt_regs.sv
// Outer register file of the multicart translator: eight 8-bit registers,
// lock handling and register-two masking. Uses mobt_pkg.
module mobt_regs
   import mobt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  wr_cmd_type     wr_cmd,
   input  logic           commit,
   output outer_regs_type regs_ff,
   output outer_regs_type regs_after
);

   logic [7:0]     r2;
   logic [7:0]     wdata;
   logic           allowed;
   outer_regs_type regs_in;

   always_comb begin
      r2      = regs_ff[REG_CHR_HI];
      wdata   = wr_cmd.data;
      allowed = !regs_ff[REG_LOCK][LOCK_BIT] || (wr_cmd.idx == REG_CHR_HI);
      if (wr_cmd.idx == REG_CHR_HI) begin
         if (r2[7]) begin
            wdata = {r2[7:4], wdata[3:0]};
         end
         // bits 3:1 open only where reg2 bits 6:4 are clear
         wdata = wdata & (REG2_KEEP_MASK | {4'b0, ~r2[6:4], 1'b0});
      end
      regs_after = regs_ff;
      if (wr_cmd.valid && allowed) begin
         regs_after[wr_cmd.idx] = wdata;
      end
      regs_in = commit ? regs_after : regs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

>>> design/mobt_xlate.sv
// Bank translation logic: PRG and CHR outer-bank merge, CHR-RAM window,
// write protect and mirroring. Purely combinational. Uses mobt_pkg.
module mobt_xlate
   import mobt_pkg::*;
(
   input  logic [1:0]     kind,
   input  logic [15:0]    access_addr,
   input  logic [7:0]     data_value,
   input  logic           inner_mirror_bit,
   input  logic           inner_prg0_top_bit,
   input  board_cfg_type  cfg,
   input  outer_regs_type regs,
   input  logic [7:0]     r0_after,
   output result_type     result
);

   logic [7:0]           r0, r1, r2, r3, r4;
   logic                 gnrom;
   layout_fam_type       fam;
   logic [7:0]           p_mask_in, p_mask_all;
   logic [1:0]           p_mask_g;
   logic [BankWidth-1:0] p_base_d, p_base, p_bank;
   logic                 chip_sel;
   logic [7:0]           c_mask_in, c_mask_all;
   logic [2:0]           c_mask_g;
   logic [BankWidth-1:0] c_base, c_bank;
   logic                 ram_hit;
   logic [1:0]           mirror;

   always_comb begin
      r0    = regs[REG_MODE];
      r1    = regs[REG_OUTER1];
      r2    = regs[REG_CHR_HI];
      r3    = regs[REG_LOCK];
      r4    = regs[REG_RAM_WIN];
      gnrom = r3[4];
      fam   = layout_fam_type'(cfg.board_variant[3:1]);

      // PRG side
      p_mask_in = {r1[5], r1[6], ~r1[7], ~r0[6], gnrom ? 4'h0 : 4'hF};
      p_base_d  = {1'b0, r0[5:4], r1[3:2], r1[4], r0[2:0], r3[3:1], 1'b0};
      chip_sel  = r0[7] ? r0[3] : inner_prg0_top_bit;
      p_mask_g  = 2'b00;
      case (fam)
         FAM_REV_R1: begin
            p_mask_g = gnrom ? (r1[4] ? 2'b01 : 2'b11) : 2'b00;
            p_base   = {1'b0, r0[5:4], r1[1], r1[2], r1[3], r0[2:0], r3[3:1], 1'b0};
         end
         FAM_PRG_HI: begin
            p_mask_g = gnrom ? (r1[1] ? 2'b11 : 2'b01) : 2'b00;
            p_base   = {4'b0, r0[5:4], r0[2:0], r3[3:1], 1'b0};
         end
         FAM_TWO_CHP: begin
            // chip size zero wraps to an all-ones mask and adds nothing
            p_mask_g = gnrom ? (r1[1] ? 2'b11 : 2'b01) : 2'b00;
            p_base   = p_base_d & (cfg.chip_half_banks - 1'b1);
            if (chip_sel) begin
               p_base = p_base | cfg.chip_half_banks;
            end
         end
         default: begin
            p_mask_g = gnrom ? (r1[1] ? 2'b11 : 2'b01) : 2'b00;
            p_base   = p_base_d | {~r1[0], 12'b0};
         end
      endcase
      p_mask_all = p_mask_in | {6'b0, p_mask_g};
      p_bank = (p_base & ~{5'b0, p_mask_all}) | {5'b0, data_value & p_mask_in}
             | {11'b0, access_addr[14:13] & p_mask_g};

      // CHR side
      c_base     = {3'b0, r0[5:3], r2[3:0], 3'b0};
      c_mask_in  = gnrom ? 8'h00 : (r0[7] ? CHR_MASK_HALF : CHR_MASK_FULL);
      c_mask_g   = gnrom ? 3'h7 : 3'h0;
      c_mask_all = c_mask_in | {5'b0, c_mask_g};
      c_bank = (c_base & ~{5'b0, c_mask_all}) | {5'b0, data_value & c_mask_in}
             | {10'b0, access_addr[12:10] & c_mask_g};
      ram_hit = cfg.chr_ram_present && r4[0] && (data_value[7:1] == r4[7:1]);

      // mirroring sees register 0 after a write in this same word
      if (!r0_after[5] && (fam == FAM_SINGLE)) begin
         mirror = {1'b1, r0_after[4]};
      end else begin
         mirror = {1'b0, ~inner_mirror_bit};
      end

      result             = '0;
      result.mirror_mode = mirror;
      case (kind)
         KIND_PRG: begin
            result.bank_number = p_bank;
         end
         KIND_CHR: begin
            result.bank_number      = c_bank;
            result.use_chr_ram      = ram_hit;
            result.chr_write_enable = ram_hit || !((fam == FAM_CHR_WP) && r0[4]);
         end
         default: begin
            result.bank_number = '0;
         end
      endcase
   end

endmodule

>>> design/multicart_outer_bank_translator.sv
// Top level of the multicart outer-bank translator.
// Instantiates mobt_regs and mobt_xlate; uses mobt_pkg.
//
// Usage:
//  - req_* stream: one word per CPU/PPU access. tuser selects the request kind
//    (outer register write, PRG translate, CHR translate; code 3 is consumed
//    and gives no response word). tdata carries address, data and the inner
//    mapper's mirroring bit and PRG bank 0 top bit.
//  - rsp_* stream: one word per accepted request of a known kind, in order:
//    translated bank, CHR-RAM hit, CHR write enable, mirroring mode.
//    A register write answers with bank zero and the mirroring after the write.
//  - csr_* port: board variant, PRG chip size and CHR-RAM presence; always ready.
//    The user writes it only while no request is in flight; the block does not enforce this.
// A request passes the input register, the translation logic and the output register
// before rsp_tvalid rises. One word per cycle while rsp_tready stays high;
// writes commit as the word leaves the input register.
// Reset clears the outer registers, both pipeline valids and the board
// configuration (variant 0, chip size 256, no CHR-RAM).
// When rsp_tready is low the output register holds its word; the input
// register keeps accepting until it is also full, then req_tready drops.
module multicart_outer_bank_translator
   import mobt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // access_addr[15:0], data_value[23:16],
                                   // inner_mirror_bit[24], inner_prg0_top_bit[25]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // bank_number[12:0], use_chr_ram[13],
                                   // chr_write_enable[14], mirror_mode[16:15]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   // board configuration
   board_cfg_type  cfg_ff;

   // input stage
   logic           in_valid_ff;
   logic [1:0]     in_kind_ff;
   logic [15:0]    in_addr_ff;
   logic [7:0]     in_data_ff;
   logic           in_mirror_ff;
   logic           in_top_ff;

   // output stage
   logic           out_valid_ff;
   result_type     out_result_ff;

   logic           in_known;
   logic           out_free;
   logic           advance;
   logic           commit;
   wr_cmd_type     wr_cmd;
   outer_regs_type regs;
   outer_regs_type regs_after;
   result_type     result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_variant   <= '0;
         cfg_ff.chip_half_banks <= CHIP_DEFAULT;
         cfg_ff.chr_ram_present <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOARD_VARIANT:   cfg_ff.board_variant   <= csr_data[3:0];
            CSR_CHIP_HALF_BANKS: cfg_ff.chip_half_banks <= csr_data;
            CSR_CHR_RAM_PRESENT: cfg_ff.chr_ram_present <= csr_data[0];
            default: begin
               // unknown index: nothing to write
            end
         endcase
      end
   end

   // Unknown request kinds leave the input stage without needing the output.
   assign in_known   = (in_kind_ff == KIND_WRITE) || (in_kind_ff == KIND_PRG)
                    || (in_kind_ff == KIND_CHR);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_known || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign commit     = advance && (in_kind_ff == KIND_WRITE);

   assign wr_cmd.valid = in_valid_ff && (in_kind_ff == KIND_WRITE);
   assign wr_cmd.idx   = in_addr_ff[2:0];
   assign wr_cmd.data  = in_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff   <= req_tuser;
         in_addr_ff   <= req_tdata[15:0];
         in_data_ff   <= req_tdata[23:16];
         in_mirror_ff <= req_tdata[24];
         in_top_ff    <= req_tdata[25];
      end
   end

   mobt_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .wr_cmd     (wr_cmd),
      .commit     (commit),
      .regs_ff    (regs),
      .regs_after (regs_after)
   );

   mobt_xlate u_xlate (
      .kind               (in_kind_ff),
      .access_addr        (in_addr_ff),
      .data_value         (in_data_ff),
      .inner_mirror_bit   (in_mirror_ff),
      .inner_prg0_top_bit (in_top_ff),
      .cfg                (cfg_ff),
      .regs               (regs),
      .r0_after           (regs_after[REG_MODE]),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && in_known;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && in_known) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_result_ff};

   // a locked register (other than register two) never changes on a write
   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      (commit && regs[REG_LOCK][LOCK_BIT] && (in_addr_ff[2:0] != REG_CHR_HI))
      |=> $stable(regs))
      else $error("locked outer register changed");

   // a register write answers with bank zero and no CHR flags
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_kind_ff == KIND_WRITE))
      |=> (rsp_tvalid && (rsp_tdata[14:0] == 15'd0)))
      else $error("write response carries bank or CHR flags");

   // a CHR-RAM hit is always writable
   a_ram_we: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[13]) |-> rsp_tdata[14])
      else $error("CHR-RAM hit without write enable");

   // an unknown request kind never creates a response
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_known && !out_valid_ff) |=> !rsp_tvalid)
      else $error("unknown request produced a response");

   // nothing is presented right after a reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff))
      else $error("pipeline valid after reset");

endmodule

>>> sim/tb_top.sv
// Self-checking bench for multicart_outer_bank_translator.
// Streams writes and PRG/CHR lookups under random flow control and checks every response word.
// Depends on design/mobt_pkg.sv and the translator RTL.
module tb_top;
   import mobt_pkg::*;

   // Request kind 3 is consumed by the block and answers nothing
   localparam logic [1:0] KIND_NONE = 2'd3;

   // Settling margin after the last owed response before touching the CSRs
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   multicart_outer_bank_translator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: outer registers and board configuration
   // ---------------------------------------------------------------------
   logic [7:0]    outer_q [NumOuterRegs];
   board_cfg_type board_cfg;

   // Responses owed by the block, oldest first
   result_type    lookups_due [$];

   int unsigned   err_count   = 0;
   int unsigned   snd_idle    = 0;   // percent of cycles the sender sits out
   int unsigned   rcv_idle    = 0;   // percent of cycles the receiver stalls
   int unsigned   hold_asks   = 0;   // bumped by a test to request a long stall
   int unsigned   hold_seen   = 0;
   int unsigned   hold_left   = 0;
   int unsigned   cycle_count = 0;
   int unsigned   cfg_no      = 0;
   result_type    rsp_got;
   result_type    rsp_want;

   // PRG: inner 8 KiB bank merged with the masked outer base
   function automatic logic [12:0] prg_bank(logic [15:0] addr, logic [7:0] v, logic top);
      logic [31:0]    r0, r1, r3, mask_in, mask_g, base, chip_sz, merged;
      layout_fam_type fam;
      logic           upper_chip;
      r0  = 32'(outer_q[REG_MODE]);
      r1  = 32'(outer_q[REG_OUTER1]);
      r3  = 32'(outer_q[REG_LOCK]);
      fam = layout_fam_type'(board_cfg.board_variant[3:1]);
      // reg3 bit4 is GNROM mode: inner low nibble no longer passes through
      mask_in = (r3[4] ? 32'h0 : 32'h0F) | ((~r0 >> 2) & 32'h10) | ((~r1 >> 2) & 32'h20)
              | (r1 & 32'h40) | ((r1 << 2) & 32'h80);
      if (fam == FAM_REV_R1) begin
         mask_g = r3[4] ? (r1[4] ? 32'h1 : 32'h3) : 32'h0;
         base = (r3 & 32'h0E) | ((r0 << 4) & 32'h70) | ((r1 << 4) & 32'h80)
              | ((r1 << 6) & 32'h100) | ((r1 << 8) & 32'h200) | ((r0 << 6) & 32'hC00);
      end else begin
         mask_g = r3[4] ? (r1[1] ? 32'h3 : 32'h1) : 32'h0;
         if (fam == FAM_PRG_HI) begin
            base = (r3 & 32'h0E) | ((r0 << 4) & 32'h70) | ((r0 << 3) & 32'h180);
         end else begin
            base = (r3 & 32'h0E) | ((r0 << 4) & 32'h70) | ((r1 << 3) & 32'h80)
                 | ((r1 << 6) & 32'h300) | ((r0 << 6) & 32'hC00);
            if (fam == FAM_TWO_CHP) begin
               // chip size zero wraps to an all-ones mask and adds nothing
               chip_sz    = 32'(board_cfg.chip_half_banks);
               base       = base & (chip_sz - 32'd1);
               upper_chip = r0[7] ? r0[3] : top;
               if (upper_chip) begin
                  base = base | chip_sz;
               end
            end else begin
               base = base | ((~r1 << 12) & 32'h1000);
            end
         end
      end
      merged = (base & ~(mask_in | mask_g)) | (32'(v) & mask_in)
             | ((32'(addr) >> 13) & mask_g);
      return merged[12:0];
   endfunction

   // Apply one request to the shadow; returns 1 when a response word is owed
   function automatic bit predict_lookup(logic [1:0] kind, logic [15:0] addr, logic [7:0] v,
                                         logic mir, logic top, output result_type res);
      logic [2:0]  idx;
      logic [7:0]  r2, wv;
      logic [31:0] r0, base, mask_in, mask_g, merged;
      res = '0;
      if (kind == KIND_NONE) begin
         return 1'b0;
      end
      if (kind == KIND_WRITE) begin
         idx = addr[2:0];
         wv  = v;
         // lock bit freezes everything except reg2
         if (!outer_q[REG_LOCK][LOCK_BIT] || idx == REG_CHR_HI) begin
            if (idx == REG_CHR_HI) begin
               r2 = outer_q[REG_CHR_HI];
               if (r2[7]) begin
                  wv = {r2[7:4], wv[3:0]};
               end
               wv = wv & (REG2_KEEP_MASK | ((~r2 >> 3) & 8'h0E));
            end
            outer_q[idx] = wv;
         end
      end else if (kind == KIND_PRG) begin
         res.bank_number = prg_bank(addr, v, top);
      end else begin
         r0      = 32'(outer_q[REG_MODE]);
         base    = ((r0 << 4) & 32'h380) | ((32'(outer_q[REG_CHR_HI]) << 3) & 32'h078);
         mask_in = outer_q[REG_LOCK][4] ? 32'h0 : (r0[7] ? 32'h7F : 32'hFF);
         mask_g  = outer_q[REG_LOCK][4] ? 32'h7 : 32'h0;
         merged  = (base & ~(mask_in | mask_g)) | (32'(v) & mask_in)
                 | ((32'(addr) >> 10) & mask_g);
         res.bank_number = merged[12:0];
         if (board_cfg.chr_ram_present && outer_q[REG_RAM_WIN][0]
             && v[7:1] == outer_q[REG_RAM_WIN][7:1]) begin
            res.use_chr_ram      = 1'b1;
            res.chr_write_enable = 1'b1;
         end else begin
            res.chr_write_enable =
               !(layout_fam_type'(board_cfg.board_variant[3:1]) == FAM_CHR_WP
                 && outer_q[REG_MODE][4]);
         end
      end
      // mirroring is taken after any write above
      if (!outer_q[REG_MODE][5]
          && layout_fam_type'(board_cfg.board_variant[3:1]) == FAM_SINGLE) begin
         res.mirror_mode = {1'b1, outer_q[REG_MODE][4]};
      end else begin
         res.mirror_mode = {1'b0, ~mir};
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Flow control, checking and timeout
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("tb_top: mismatch on %s: got %0h want %0h (cycle %0d)",
               what, got, want, cycle_count);
      err_count++;
   endtask

   // Receiver: random stalls, or a long hold when a test asks for one
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen  <= hold_asks;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // Every accepted response word is matched against the oldest owed lookup
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         rsp_got = result_type'(rsp_tdata[16:0]);
         if (lookups_due.size() == 0) begin
            report_mismatch("unexpected response word", 32'(rsp_tdata), 32'd0);
         end else begin
            rsp_want = lookups_due.pop_front();
            if (rsp_got.bank_number !== rsp_want.bank_number)
               report_mismatch("bank_number", 32'(rsp_got.bank_number),
                               32'(rsp_want.bank_number));
            if (rsp_got.use_chr_ram !== rsp_want.use_chr_ram)
               report_mismatch("use_chr_ram", 32'(rsp_got.use_chr_ram),
                               32'(rsp_want.use_chr_ram));
            if (rsp_got.chr_write_enable !== rsp_want.chr_write_enable)
               report_mismatch("chr_write_enable", 32'(rsp_got.chr_write_enable),
                               32'(rsp_want.chr_write_enable));
            if (rsp_got.mirror_mode !== rsp_want.mirror_mode)
               report_mismatch("mirror_mode", 32'(rsp_got.mirror_mode),
                               32'(rsp_want.mirror_mode));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Offer one request word; valid stays up after acceptance so that
   // back-to-back words follow without a gap.
   task automatic send_word(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] v, input logic mir, input logic top);
      result_type res;
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, top, mir, v, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_lookup(kind, addr, v, mir, top, res)) begin
         lookups_due.push_back(res);
      end
   endtask

   task automatic send_write(input logic [2:0] idx, input logic [7:0] v);
      send_word(KIND_WRITE, {13'($urandom), idx}, v, 1'($urandom), 1'($urandom));
   endtask

   // Sender pauses until every owed word is back, plus SETTLE_CYCLES idle clocks
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Board configuration write; only called with the pipe drained
   task automatic write_board_reg(input logic [1:0] idx, input logic [12:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BOARD_VARIANT:   board_cfg.board_variant   = val[3:0];
         CSR_CHIP_HALF_BANKS: board_cfg.chip_half_banks = val;
         CSR_CHR_RAM_PRESENT: board_cfg.chr_ram_present = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Random request. Before the lock phase, writes to reg2/reg3 keep bit 7
   // clear: the lock and the reg2 keep bit are sticky until reset.
   task automatic send_random(input bit locked);
      int unsigned pick;
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  v;
      pick = $urandom_range(99);
      kind = (pick < 25) ? KIND_WRITE : (pick < 60) ? KIND_PRG :
             (pick < 95) ? KIND_CHR : KIND_NONE;
      addr = 16'($urandom);
      v    = 8'($urandom);
      if (kind == KIND_WRITE && !locked
          && (addr[2:0] == REG_LOCK || addr[2:0] == REG_CHR_HI)) begin
         v[7] = 1'b0;
      end
      // aim a quarter of CHR lookups at the CHR-RAM window
      if (kind == KIND_CHR && $urandom_range(3) == 0) begin
         v[7:1] = outer_q[REG_RAM_WIN][7:1];
      end
      send_word(kind, addr, v, 1'($urandom), 1'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Lookups straight out of reset, field extremes, and a dropped kind
   task automatic test_defaults();
      send_word(KIND_PRG, 16'h0000, 8'h00, 1'b0, 1'b0);
      send_word(KIND_PRG, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
      send_word(KIND_CHR, 16'h0000, 8'h00, 1'b0, 1'b0);
      send_word(KIND_CHR, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
      send_word(KIND_NONE, 16'hFFFF, 8'hAA, 1'b1, 1'b1);
   endtask

   // Directed walk through GNROM, single-screen, CHR-RAM window,
   // write protect and the two-chip select
   task automatic test_directed_modes();
      send_write(REG_MODE, 8'hFF);
      send_write(REG_OUTER1, 8'hFF);
      send_write(REG_LOCK, 8'h7F);
      send_write(REG_RAM_WIN, 8'hFF);
      send_word(KIND_PRG, 16'h6000, 8'h5A, 1'b0, 1'b1);
      send_word(KIND_CHR, 16'h1C00, 8'hFE, 1'b1, 1'b0);
      send_write(REG_MODE, 8'h00);
      send_write(REG_OUTER1, 8'h00);
      send_write(REG_LOCK, 8'h10);
      send_word(KIND_PRG, 16'h6000, 8'h00, 1'b1, 1'b0);
      send_word(KIND_CHR, 16'h1C00, 8'h00, 1'b0, 1'b1);
      drain_pipe();
      write_board_reg(CSR_BOARD_VARIANT, {9'h1FF, 4'd10});
      write_board_reg(CSR_CHR_RAM_PRESENT, 13'h1FFF);
      send_write(REG_MODE, 8'h10);           // single screen B
      send_write(REG_RAM_WIN, 8'h35);        // window 34/35
      send_word(KIND_CHR, 16'h0400, 8'h35, 1'b0, 1'b0);
      send_word(KIND_CHR, 16'h0400, 8'h36, 1'b1, 1'b0);
      drain_pipe();
      write_board_reg(CSR_BOARD_VARIANT, 13'd8);
      send_word(KIND_CHR, 16'h0800, 8'h22, 1'b0, 1'b1);
      drain_pipe();
      write_board_reg(CSR_BOARD_VARIANT, 13'd6);
      write_board_reg(CSR_CHIP_HALF_BANKS, 13'd0);
      send_write(REG_MODE, 8'h88);           // chip picked by reg0 bit 3
      send_word(KIND_PRG, 16'h2000, 8'h33, 1'b0, 1'b0);
      drain_pipe();
      write_board_reg(CSR_CHIP_HALF_BANKS, 13'd4096);
      send_write(REG_MODE, 8'h00);           // chip picked by inner bank 0 bit 7
      send_word(KIND_PRG, 16'h4000, 8'hC3, 1'b1, 1'b1);
   endtask

   // A run of board settings, each followed by random traffic. Variants
   // step through all sixteen codes; chip size starts at the extremes.
   task automatic test_random_settings(input int unsigned count);
      logic [12:0] chip_val;
      repeat (count) begin
         drain_pipe();
         case (cfg_no)
            0:       chip_val = 13'd1;
            1:       chip_val = 13'd4096;
            2:       chip_val = 13'd0;
            3:       chip_val = 13'h1FFF;
            default: chip_val = ($urandom_range(1) != 0) ? 13'(1 << $urandom_range(12))
                                                         : 13'($urandom);
         endcase
         write_board_reg(CSR_BOARD_VARIANT, {9'($urandom), 4'(cfg_no)});
         write_board_reg(CSR_CHIP_HALF_BANKS, chip_val);
         write_board_reg(CSR_CHR_RAM_PRESENT,
                         {12'($urandom), (cfg_no < 2) ? 1'(cfg_no) : 1'($urandom)});
         repeat (35) send_random(1'b0);
         cfg_no++;
      end
   endtask

   // Receiver stops for a long stretch while the sender keeps pushing,
   // so the pipe fills and req_tready has to drop
   task automatic test_backpressure();
      int unsigned saved_idle;
      saved_idle = snd_idle;
      snd_idle   = 0;
      hold_asks++;
      repeat (40) send_random(1'b0);
      snd_idle = saved_idle;
      drain_pipe();
   endtask

   // reg2 keep bits, then the lock; both last until reset so this runs last
   task automatic test_sticky_regs();
      send_write(REG_CHR_HI, 8'hFF);
      send_write(REG_CHR_HI, 8'h0E);
      send_word(KIND_CHR, 16'h0000, 8'h01, 1'b0, 1'b0);
      send_write(REG_LOCK, 8'h80);
      send_write(REG_MODE, 8'hFF);           // dropped while locked
      send_write(REG_CHR_HI, 8'h01);         // reg2 still takes writes
      send_word(KIND_PRG, 16'hE000, 8'h7E, 1'b1, 1'b0);
      send_word(KIND_CHR, 16'h1400, 8'h80, 1'b0, 1'b1);
      repeat (50) send_random(1'b1);
   endtask

   initial begin
      foreach (outer_q[i]) outer_q[i] = 8'h00;
      board_cfg.board_variant   = 4'd0;
      board_cfg.chip_half_banks = CHIP_DEFAULT;
      board_cfg.chr_ram_present = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle = 38;
      rcv_idle = 47;
      test_defaults();
      test_directed_modes();
      test_random_settings(6);

      snd_idle = 47;
      rcv_idle = 38;
      test_random_settings(5);
      test_backpressure();

      snd_idle = 0;
      rcv_idle = 0;
      test_random_settings(5);
      test_sticky_regs();

      drain_pipe();
      if (err_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
